FILE: design/sip_pkg.sv
package sip_pkg;
  localparam int unsigned FieldWidth = 32;
endpackage

FILE: design/sip_if.sv
interface sip_in_if #(
  parameter int unsigned Width = 32
);
  logic valid;
  logic ready;
  logic signed [Width-1:0] a_start_x, a_start_y, a_end_x, a_end_y;
  logic signed [Width-1:0] b_start_x, b_start_y, b_end_x, b_end_y;
  modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  output b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                input b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface sip_out_if #(
  parameter int unsigned Width = 32
);
  logic valid;
  logic ready;
  logic hit;
  logic signed [Width-1:0] cross_x, cross_y;
  modport source (output valid, hit, cross_x, cross_y, input ready);
  modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

FILE: design/sip_divider.sv
// Pipelined restoring divider: one quotient bit per stage.
// Quotient fits QW bits because num <= den times |delta| < 2**QW.
module sip_divider import sip_pkg::*; #(
  parameter int unsigned NW = 96,
  parameter int unsigned DW = 66,
  parameter int unsigned QW = 33,
  parameter int unsigned TW = 65
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic [QW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);
  // partial remainder stays below den, so DW+1 bits carry it
  logic [DW:0]   rem_q [QW+1];
  logic [NW-1:0] num_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [TW-1:0] tag_q [QW+1];

  // start from the numerator bits above the quotient; they lie below den
  always_comb begin
    rem_q[0] = (DW+1)'(num_i[NW-1:QW]);
    num_q[0] = num_i;
    den_q[0] = den_i;
    quo_q[0] = '0;
    tag_q[0] = tag_i;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW+1:0] trial_d;
    logic [DW:0]   rem_d;
    logic [QW-1:0] quo_d;
    logic [DW:0]   rem_r;
    logic [NW-1:0] num_r;
    logic [DW-1:0] den_r;
    logic [QW-1:0] quo_r;
    logic [TW-1:0] tag_r;
    // shift in next numerator bit and try a subtract
    always_comb begin
      trial_d = {rem_q[s], num_q[s][QW-1-s]} - {2'b00, den_q[s]};
      if (!trial_d[DW+1]) rem_d = trial_d[DW:0];
      else rem_d = {rem_q[s][DW-1:0], num_q[s][QW-1-s]};
      quo_d = quo_q[s];
      quo_d[QW-1-s] = !trial_d[DW+1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_r <= rem_d;
        num_r <= num_q[s];
        den_r <= den_q[s];
        quo_r <= quo_d;
        tag_r <= tag_q[s];
      end
    end
    always_comb begin
      rem_q[s+1] = rem_r;
      num_q[s+1] = num_r;
      den_q[s+1] = den_r;
      quo_q[s+1] = quo_r;
      tag_q[s+1] = tag_r;
    end
  end

  assign quo_o = quo_q[QW];
  assign tag_o = tag_q[QW];
endmodule

FILE: design/segment_intersection_point_unit.sv
// Streaming 2D segment crossing unit. Accepts one segment pair per cycle
// while the output is not stalled and returns hit plus the crossing point
// after the product, sum, lerp and bit-per-stage divider pipeline. The
// pipeline advances whenever its output slot is free or being taken, so
// downstream stalls freeze all stages without losing items.
// Inputs use only the low COORD_WIDTH bits, sign-extended.
module segment_intersection_point_unit import sip_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input logic clk_i,
  input logic rst_ni,
  sip_in_if.sink   req_i,
  sip_out_if.source res_o
);
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DFW = CW + 1;        // difference width
  localparam int unsigned PW = 2 * DFW;        // product width
  localparam int unsigned SW = PW + 1;         // sum width
  localparam int unsigned NW = SW + DFW;       // lerp product width
  localparam int unsigned LoW = SW - DFW;      // low slice of num for lerp
  localparam int unsigned PLW = DFW + LoW;     // low partial product width
  localparam int unsigned PHW = 2 * DFW;       // high partial product width
  localparam int unsigned QW = DFW;            // quotient width
  localparam int unsigned TW = 1 + 2 * CW + 2; // tag: hit, starts, signs
  localparam int unsigned DLAT = QW;
  localparam int unsigned LAT = 7 + DLAT;
  localparam int unsigned FracUnused = FRAC_BITS;

  logic en;
  logic [LAT-1:0] vld_q;

  assign en = !res_o.valid || res_o.ready;
  assign req_i.ready = en;

  // stage 1: sign-extend and form differences
  logic signed [CW-1:0] asx, asy, aex, aey, bsx, bsy;
  logic signed [DFW-1:0] d_bxs_d, d_ayse_d, d_axse_d, d_bys_d, d_axb_d, d_ayb_d;
  logic signed [DFW-1:0] d_bxs_q, d_ayse_q, d_axse_q, d_bys_q, d_axb_q, d_ayb_q;
  logic signed [CW-1:0] s1_asx_q, s1_asy_q;
  logic signed [CW-1:0] bex, bey;
  always_comb begin
    asx = req_i.a_start_x[CW-1:0];
    asy = req_i.a_start_y[CW-1:0];
    aex = req_i.a_end_x[CW-1:0];
    aey = req_i.a_end_y[CW-1:0];
    bsx = req_i.b_start_x[CW-1:0];
    bsy = req_i.b_start_y[CW-1:0];
    bex = req_i.b_end_x[CW-1:0];
    bey = req_i.b_end_y[CW-1:0];
    d_bxs_d  = DFW'(bex) - DFW'(bsx);
    d_ayse_d = DFW'(asy) - DFW'(aey);
    d_axse_d = DFW'(asx) - DFW'(aex);
    d_bys_d  = DFW'(bey) - DFW'(bsy);
    d_axb_d  = DFW'(asx) - DFW'(bsx);
    d_ayb_d  = DFW'(asy) - DFW'(bsy);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_bxs_q <= d_bxs_d; d_ayse_q <= d_ayse_d; d_axse_q <= d_axse_d;
      d_bys_q <= d_bys_d; d_axb_q <= d_axb_d; d_ayb_q <= d_ayb_d;
      s1_asx_q <= asx; s1_asy_q <= asy;
    end
  end

  // stage 2: six products (num_a uses -d_bys, num_b uses -d_axse)
  logic signed [PW-1:0] p_den1_q, p_den2_q, p_na1_q, p_na2_q, p_nb1_q, p_nb2_q;
  logic signed [DFW-1:0] s2_dx_q, s2_dy_q;
  logic signed [CW-1:0] s2_asx_q, s2_asy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_den1_q <= PW'(d_bxs_q) * PW'(d_ayse_q);
      p_den2_q <= PW'(d_axse_q) * PW'(d_bys_q);
      p_na1_q  <= PW'(d_bys_q) * PW'(d_axb_q);
      p_na2_q  <= PW'(d_bxs_q) * PW'(d_ayb_q);
      p_nb1_q  <= PW'(d_ayse_q) * PW'(d_axb_q);
      p_nb2_q  <= PW'(d_axse_q) * PW'(d_ayb_q);
      s2_dx_q <= -d_axse_q;
      s2_dy_q <= d_ayse_q;
      s2_asx_q <= s1_asx_q; s2_asy_q <= s1_asy_q;
    end
  end

  // stage 3: sums, normalize den sign
  logic signed [SW-1:0] den_d, na_d, nb_d;
  logic signed [SW-1:0] den_q, na_q, nb_q;
  logic signed [DFW-1:0] s3_dx_q, s3_dy_q;
  logic signed [CW-1:0] s3_asx_q, s3_asy_q;
  always_comb begin
    den_d = SW'(p_den1_q) - SW'(p_den2_q);
    na_d  = -(SW'(p_na1_q)) + SW'(p_na2_q);
    nb_d  = SW'(p_nb1_q) - SW'(p_nb2_q);
    // delta (asy-aey) is -dy, so correct sign: dy = aey-asy
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (den_d[SW-1]) begin
        den_q <= -den_d; na_q <= -na_d; nb_q <= -nb_d;
      end else begin
        den_q <= den_d; na_q <= na_d; nb_q <= nb_d;
      end
      s3_dx_q <= s2_dx_q;
      s3_dy_q <= -s2_dy_q;
      s3_asx_q <= s2_asx_q; s3_asy_q <= s2_asy_q;
    end
  end

  // stage 4: range tests, absolute deltas
  logic s4_hit_q;
  logic [SW-1:0] s4_den_q, s4_na_q;
  logic [DFW-1:0] s4_adx_q, s4_ady_q;
  logic s4_nx_q, s4_ny_q;
  logic signed [CW-1:0] s4_asx_q, s4_asy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_hit_q <= (den_q != '0) && !na_q[SW-1] && (na_q <= den_q)
                  && !nb_q[SW-1] && (nb_q <= den_q);
      s4_den_q <= den_q;
      s4_na_q <= na_q;
      s4_adx_q <= s3_dx_q[DFW-1] ? -s3_dx_q : s3_dx_q;
      s4_ady_q <= s3_dy_q[DFW-1] ? -s3_dy_q : s3_dy_q;
      s4_nx_q <= s3_dx_q[DFW-1];
      s4_ny_q <= s3_dy_q[DFW-1];
      s4_asx_q <= s3_asx_q; s4_asy_q <= s3_asy_q;
    end
  end

  // stage 5: partial lerp products |delta| * low and high slices of num
  logic [PLW-1:0] s5a_plx_q, s5a_ply_q;
  logic [PHW-1:0] s5a_phx_q, s5a_phy_q;
  logic [SW-1:0] s5a_den_q;
  logic [TW-1:0] s5a_tag_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s5a_plx_q <= PLW'(s4_adx_q) * PLW'(s4_na_q[LoW-1:0]);
      s5a_ply_q <= PLW'(s4_ady_q) * PLW'(s4_na_q[LoW-1:0]);
      s5a_phx_q <= PHW'(s4_adx_q) * PHW'(s4_na_q[SW-1:LoW]);
      s5a_phy_q <= PHW'(s4_ady_q) * PHW'(s4_na_q[SW-1:LoW]);
      s5a_den_q <= s4_hit_q ? s4_den_q : SW'(1);
      s5a_tag_q <= {s4_hit_q, s4_nx_q, s4_ny_q, s4_asx_q, s4_asy_q};
    end
  end

  // stage 6: combine partial products into |delta| * num
  logic [NW-1:0] s5_px_q, s5_py_q;
  logic [SW-1:0] s5_den_q;
  logic [TW-1:0] s5_tag_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_px_q <= NW'(s5a_plx_q) + (NW'(s5a_phx_q) << LoW);
      s5_py_q <= NW'(s5a_ply_q) + (NW'(s5a_phy_q) << LoW);
      s5_den_q <= s5a_den_q;
      s5_tag_q <= s5a_tag_q;
    end
  end

  // divider stages
  logic [QW-1:0] qx, qy;
  logic [TW-1:0] tag_x, tag_y;
  sip_divider #(.NW(NW), .DW(SW), .QW(QW), .TW(TW)) u_div_x (
    .clk_i, .en_i(en), .num_i(s5_px_q), .den_i(s5_den_q), .tag_i(s5_tag_q),
    .quo_o(qx), .tag_o(tag_x)
  );
  sip_divider #(.NW(NW), .DW(SW), .QW(QW), .TW(TW)) u_div_y (
    .clk_i, .en_i(en), .num_i(s5_py_q), .den_i(s5_den_q), .tag_i(s5_tag_q),
    .quo_o(qy), .tag_o(tag_y)
  );

  // final stage: apply sign, add start, zero on miss
  logic t_hit, t_nx, t_ny;
  logic signed [CW-1:0] t_asx, t_asy, rx_d, ry_d;
  logic hit_q;
  logic signed [FieldWidth-1:0] cx_q, cy_q;
  always_comb begin
    {t_hit, t_nx, t_ny, t_asx, t_asy} = tag_x;
    rx_d = t_asx + (t_nx ? -CW'(qx) : CW'(qx));
    ry_d = t_asy + (t_ny ? -CW'(qy) : CW'(qy));
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= t_hit;
      cx_q <= t_hit ? FieldWidth'(rx_d) : '0;
      cy_q <= t_hit ? FieldWidth'(ry_d) : '0;
    end
  end

  // advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], req_i.valid};
    end
  end

  assign res_o.valid = vld_q[LAT-1];
  assign res_o.hit = hit_q;
  assign res_o.cross_x = cx_q;
  assign res_o.cross_y = cy_q;

  logic unused;
  assign unused = ^tag_y ^ (FracUnused == 0);
endmodule
